[hw/rtl/hbos_pkg.sv]
package hbos_pkg;

	// Set geometry
	localparam int unsigned UNIVERSE = 4096;
	localparam int unsigned WORD_W   = 64;
	localparam int unsigned IDX_W    = 6;
	localparam int unsigned KEY_W    = 12;
	localparam int unsigned LEAVES   = (UNIVERSE + WORD_W - 1) / WORD_W;
	localparam int unsigned LEAF_AW  = (LEAVES > 1) ? $clog2(LEAVES) : 1;

	// Operation codes
	typedef enum logic [2:0] {
		OP_INSERT   = 3'd0,
		OP_ERASE    = 3'd1,
		OP_CONTAINS = 3'd2,
		OP_MIN      = 3'd3,
		OP_MAX      = 3'd4,
		OP_PRED     = 3'd5,
		OP_SUCC     = 3'd6
	} op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEAF,
		ST_SUM,
		ST_LEAF2,
		ST_DONE
	} state_t;

	// Leaf memory request
	typedef struct packed {
		logic               rd_en;
		logic               wr_en;
		logic [LEAF_AW-1:0] addr;
		logic [WORD_W-1:0]  wdata;
	} leaf_req_t;

endpackage

[hw/rtl/hbos_bit_find.sv]
module hbos_bit_find import hbos_pkg::*; (
	input  logic [WORD_W-1:0] word,
	input  logic              find_high,
	output logic              any,
	output logic [IDX_W-1:0]  idx
);

	logic [WORD_W-1:0] w;
	logic [WORD_W-1:0] lo_mask;
	logic [WORD_W-1:0] hi_part;
	logic              hi_any;
	logic              lo_any;
	logic              take_hi;

	assign any = |word;

	// Halve the window each step: pick the half that holds the wanted bit
	always_comb begin
		w       = word;
		idx     = '0;
		lo_mask = '0;
		hi_part = '0;
		hi_any  = 1'b0;
		lo_any  = 1'b0;
		take_hi = 1'b0;
		for (int s = 0; s < IDX_W; s++) begin
			lo_mask = (WORD_W'(1) << (WORD_W >> (s + 1))) - WORD_W'(1);
			hi_part = (w >> (WORD_W >> (s + 1))) & lo_mask;
			hi_any  = |hi_part;
			lo_any  = |(w & lo_mask);
			take_hi = find_high ? hi_any : !lo_any;
			idx[IDX_W-1-s] = take_hi;
			w = take_hi ? hi_part : (w & lo_mask);
		end
	end

endmodule

[hw/rtl/hbos_leaf_ram.sv]
module hbos_leaf_ram import hbos_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  leaf_req_t         req,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [LEAVES];
	logic [LEAVES-1:0] valid_q;
	logic [WORD_W-1:0] rdata_q;
	logic              rvalid_q;

	// Mark written entries; reset empties the whole store at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rvalid_q <= valid_q[req.addr];
			end
		end
	end

	// Write and registered read of the leaf words
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.addr];
		end
	end

	// Unwritten entries read as empty
	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

[hw/rtl/hierarchical_bitmap_ordered_set_top.sv]
// Channel  | Direction | Handshake            | Payload
// in       | input     | in_valid / in_ready  | op[2:0], key[11:0]
// out      | output    | out_valid / out_ready| ok, found_key[11:0]
//
// Insert, erase and contains take a leaf read; min and max a summary search and second leaf
// read (skipped on an empty set); pred and succ a leaf read, then on a miss both of those;
// an unused op reads nothing. Every step shares the one bit finder and leaf RAM port.
// One item is in work at a time; in_ready is high only while the sequencer idles.
// Reset empties the set at once through per-word valid bits; no clearing pass.
// A result waits in the output register while the next item runs, which holds in its last step.
module hierarchical_bitmap_ordered_set_top import hbos_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       op,
	input  logic [KEY_W-1:0] key,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             ok,
	output logic [KEY_W-1:0] found_key
);

	state_t            state_q, state_d;
	logic [2:0]        op_q, op_d;
	logic [KEY_W-1:0]  key_q, key_d;
	logic [IDX_W-1:0]  p_q, p_d;
	logic              rok_q, rok_d;
	logic [KEY_W-1:0]  rkey_q, rkey_d;
	logic [WORD_W-1:0] summary_q, summary_d;
	logic              out_valid_q, out_valid_d;
	logic              ok_q, ok_d;
	logic [KEY_W-1:0]  found_key_q, found_key_d;

	leaf_req_t         req;
	logic [WORD_W-1:0] rdata;
	logic [WORD_W-1:0] find_word;
	logic              find_high;
	logic              find_any;
	logic [IDX_W-1:0]  find_idx;

	logic [IDX_W-1:0]  pos;
	logic [WORD_W-1:0] bit_mask;
	logic [WORD_W-1:0] below_bit;
	logic [WORD_W-1:0] below_pos;
	logic [WORD_W-1:0] above_pos;
	logic              in_range_q;
	logic              in_range_in;
	logic              hit;
	logic              dir_high_q;

	hbos_leaf_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata)
	);

	hbos_bit_find u_find (
		.word      (find_word),
		.find_high (find_high),
		.any       (find_any),
		.idx       (find_idx)
	);

	// Decode the held key
	assign pos         = key_q[KEY_W-1:IDX_W];
	assign bit_mask    = WORD_W'(1) << key_q[IDX_W-1:0];
	assign in_range_q  = {1'b0, key_q} < (KEY_W + 1)'(UNIVERSE);
	assign in_range_in = {1'b0, key} < (KEY_W + 1)'(UNIVERSE);
	assign hit         = |(rdata & bit_mask);
	assign dir_high_q  = (op_q == OP_MAX) || (op_q == OP_PRED);

	// Build range masks below and above the held positions
	always_comb begin
		for (int i = 0; i < WORD_W; i++) begin
			below_bit[i] = IDX_W'(i) < key_q[IDX_W-1:0];
			below_pos[i] = IDX_W'(i) < pos;
			above_pos[i] = IDX_W'(i) > pos;
		end
	end

	// Register state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			summary_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			summary_q   <= summary_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Hold the item and result payload
	always_ff @(posedge clk) begin
		op_q        <= op_d;
		key_q       <= key_d;
		p_q         <= p_d;
		rok_q       <= rok_d;
		rkey_q      <= rkey_d;
		ok_q        <= ok_d;
		found_key_q <= found_key_d;
	end

	// Sequence one item through leaf, summary and second leaf steps
	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		key_d       = key_q;
		p_d         = p_q;
		rok_d       = rok_q;
		rkey_d      = rkey_q;
		summary_d   = summary_q;
		out_valid_d = out_valid_q & ~out_ready;
		ok_d        = ok_q;
		found_key_d = found_key_q;
		in_ready    = 1'b0;
		req         = '0;
		find_word   = '0;
		find_high   = 1'b0;

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op_d     = op;
					key_d    = key;
					rok_d    = 1'b0;
					rkey_d   = '0;
					req.addr = key[IDX_W +: LEAF_AW];
					case (op)
						OP_INSERT, OP_ERASE, OP_CONTAINS, OP_SUCC: begin
							if (in_range_in) begin
								req.rd_en = 1'b1;
								state_d   = ST_LEAF;
							end else begin
								state_d = ST_DONE;
							end
						end
						OP_PRED: begin
							if (in_range_in) begin
								req.rd_en = 1'b1;
								state_d   = ST_LEAF;
							end else begin
								state_d = ST_SUM;
							end
						end
						OP_MIN, OP_MAX: begin
							state_d = ST_SUM;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end

			ST_LEAF: begin
				req.addr = pos[LEAF_AW-1:0];
				state_d  = ST_DONE;
				case (op_q)
					OP_INSERT: begin
						if (!hit) begin
							req.wr_en      = 1'b1;
							req.wdata      = rdata | bit_mask;
							summary_d[pos] = 1'b1;
							rok_d          = 1'b1;
						end
					end
					OP_ERASE: begin
						if (hit) begin
							req.wr_en = 1'b1;
							req.wdata = rdata & ~bit_mask;
							if (req.wdata == '0) begin
								summary_d[pos] = 1'b0;
							end
							rok_d = 1'b1;
						end
					end
					OP_CONTAINS: begin
						rok_d = hit;
					end
					OP_PRED, OP_SUCC: begin
						find_high = dir_high_q;
						find_word = (op_q == OP_PRED) ? (rdata & below_bit) : (rdata & ~below_bit);
						if (find_any) begin
							rok_d  = 1'b1;
							rkey_d = {pos, find_idx};
						end else begin
							state_d = ST_SUM;
						end
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end

			// Search the summary for the leaf that holds the answer
			ST_SUM: begin
				find_high = dir_high_q;
				case (op_q)
					OP_PRED: find_word = in_range_q ? (summary_q & below_pos) : summary_q;
					OP_SUCC: find_word = summary_q & above_pos;
					default: find_word = summary_q;
				endcase
				req.addr = find_idx[LEAF_AW-1:0];
				p_d      = find_idx;
				if (find_any) begin
					req.rd_en = 1'b1;
					state_d   = ST_LEAF2;
				end else begin
					state_d = ST_DONE;
				end
			end

			ST_LEAF2: begin
				find_high = dir_high_q;
				find_word = rdata;
				req.addr  = p_q[LEAF_AW-1:0];
				rok_d     = 1'b1;
				rkey_d    = {p_q, find_idx};
				state_d   = ST_DONE;
			end

			// Load the output register once it is free
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_valid_d = 1'b1;
					ok_d        = rok_q;
					found_key_d = rok_q ? rkey_q : '0;
					state_d     = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign found_key = found_key_q;

endmodule

[hw/rtl/hbos_checker.sv]
module hbos_checker import hbos_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic [2:0]       op,
	input logic [KEY_W-1:0] key,
	input logic             out_valid,
	input logic             out_ready,
	input logic             ok,
	input logic [KEY_W-1:0] found_key
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(found_key))
		else $error("result changed or dropped while stalled");

	// Hold a stalled input item
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(op) && $stable(key))
		else $error("input item changed or dropped while stalled");

	// Report no key for an empty answer
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> found_key == '0)
		else $error("found_key not zero on empty answer");

	// Stay busy after an accepted item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while previous item in work");

endmodule

bind hierarchical_bitmap_ordered_set_top hbos_checker u_hbos_checker (.*);

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
	import hbos_pkg::*;

	// Op code left free by the package; the block must treat it as a no-op
	localparam logic [2:0] OP_RESERVED = 3'd7;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 163;

	typedef struct packed {
		logic             ok;
		logic [KEY_W-1:0] found_key;
	} answer_t;

	typedef struct packed {
		logic [2:0]       op;
		logic [KEY_W-1:0] key;
		logic             pinned;
		answer_t          want;
	} row_t;

	// Directed rows; pinned rows carry an answer that is plain from the set contents
	localparam row_t DIRECTED [0:24] = '{
		'{OP_MIN,      12'd0,    1'b1, '{1'b0, 12'd0}},
		'{OP_MAX,      12'd0,    1'b1, '{1'b0, 12'd0}},
		'{OP_PRED,     12'd4095, 1'b1, '{1'b0, 12'd0}},
		'{OP_SUCC,     12'd0,    1'b1, '{1'b0, 12'd0}},
		'{OP_CONTAINS, 12'd0,    1'b1, '{1'b0, 12'd0}},
		'{OP_ERASE,    12'd0,    1'b1, '{1'b0, 12'd0}},
		'{OP_INSERT,   12'd0,    1'b1, '{1'b1, 12'd0}},
		'{OP_INSERT,   12'd4095, 1'b1, '{1'b1, 12'd0}},
		'{OP_INSERT,   12'd0,    1'b1, '{1'b0, 12'd0}},
		'{OP_MIN,      12'd123,  1'b1, '{1'b1, 12'd0}},
		'{OP_MAX,      12'd0,    1'b1, '{1'b1, 12'd4095}},
		'{OP_RESERVED, 12'd4095, 1'b1, '{1'b0, 12'd0}},
		'{OP_PRED,     12'd0,    1'b1, '{1'b0, 12'd0}},
		'{OP_SUCC,     12'd4095, 1'b1, '{1'b1, 12'd4095}},
		'{OP_INSERT,   12'd63,   1'b0, '{1'b0, 12'd0}},
		'{OP_INSERT,   12'd64,   1'b0, '{1'b0, 12'd0}},
		'{OP_INSERT,   12'd2047, 1'b0, '{1'b0, 12'd0}},
		'{OP_PRED,     12'd64,   1'b0, '{1'b0, 12'd0}},
		'{OP_SUCC,     12'd1,    1'b0, '{1'b0, 12'd0}},
		'{OP_SUCC,     12'd65,   1'b0, '{1'b0, 12'd0}},
		'{OP_PRED,     12'd2047, 1'b0, '{1'b0, 12'd0}},
		'{OP_ERASE,    12'd4095, 1'b1, '{1'b1, 12'd0}},
		'{OP_CONTAINS, 12'd4095, 1'b1, '{1'b0, 12'd0}},
		'{OP_SUCC,     12'd2048, 1'b1, '{1'b0, 12'd0}},
		'{OP_PRED,     12'd4095, 1'b0, '{1'b0, 12'd0}}
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [2:0]       op = '0;
	logic [KEY_W-1:0] key = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic             ok;
	logic [KEY_W-1:0] found_key;

	// Shadow copy of the set
	logic [WORD_W-1:0] summary_bits;
	logic [WORD_W-1:0] leaf_bits [LEAVES];

	answer_t          answers_due [$];
	int               mismatches = 0;
	logic             calm = 1'b0;
	logic [KEY_W-1:0] last_key = '0;
	logic [IDX_W-1:0] hot [4];

	hierarchical_bitmap_ordered_set_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.key       (key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ok        (ok),
		.found_key (found_key)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	function automatic int low_one(input logic [WORD_W-1:0] w);
		int n;
		n = 0;
		for (int i = WORD_W - 1; i >= 0; i--)
			if (w[i]) n = i;
		return n;
	endfunction

	function automatic int high_one(input logic [WORD_W-1:0] w);
		int n;
		n = 0;
		for (int i = 0; i < WORD_W; i++)
			if (w[i]) n = i;
		return n;
	endfunction

	// Largest member of the set, if any
	function automatic answer_t top_member();
		answer_t a;
		int p;
		a = '0;
		if (summary_bits != '0) begin
			p = high_one(summary_bits);
			a.ok = 1'b1;
			a.found_key = KEY_W'(p * WORD_W + high_one(leaf_bits[p]));
		end
		return a;
	endfunction

	// Apply one operation to the shadow set and return the answer it gives
	function automatic answer_t apply_set_op(input logic [2:0] o, input logic [KEY_W-1:0] k);
		answer_t a;
		logic [IDX_W-1:0] pos;
		logic [IDX_W-1:0] bt;
		logic [WORD_W-1:0] below;
		logic [WORD_W-1:0] m;
		logic in_range;
		int p;
		a = '0;
		pos = k[KEY_W-1:IDX_W];
		bt = k[IDX_W-1:0];
		below = (64'd1 << bt) - 64'd1;
		in_range = (k < UNIVERSE);
		case (o)
			OP_INSERT: begin
				if (in_range && !leaf_bits[pos][bt]) begin
					leaf_bits[pos][bt] = 1'b1;
					summary_bits[pos] = 1'b1;
					a.ok = 1'b1;
				end
			end
			OP_ERASE: begin
				if (in_range && leaf_bits[pos][bt]) begin
					leaf_bits[pos][bt] = 1'b0;
					if (leaf_bits[pos] == '0) summary_bits[pos] = 1'b0;
					a.ok = 1'b1;
				end
			end
			OP_CONTAINS: a.ok = in_range && leaf_bits[pos][bt];
			OP_MIN: begin
				if (summary_bits != '0) begin
					p = low_one(summary_bits);
					a.ok = 1'b1;
					a.found_key = KEY_W'(p * WORD_W + low_one(leaf_bits[p]));
				end
			end
			OP_MAX: a = top_member();
			OP_PRED: begin
				if (!in_range) begin
					a = top_member();
				end else begin
					m = leaf_bits[pos] & below;
					if (m != '0) begin
						a.ok = 1'b1;
						a.found_key = {pos, IDX_W'(high_one(m))};
					end else begin
						m = summary_bits & ((64'd1 << pos) - 64'd1);
						if (m != '0) begin
							p = high_one(m);
							a.ok = 1'b1;
							a.found_key = KEY_W'(p * WORD_W + high_one(leaf_bits[p]));
						end
					end
				end
			end
			OP_SUCC: begin
				if (in_range) begin
					m = leaf_bits[pos] & ~below;
					if (m != '0) begin
						a.ok = 1'b1;
						a.found_key = {pos, IDX_W'(low_one(m))};
					end else if (pos != IDX_W'(LEAVES - 1)) begin
						m = summary_bits & (~64'd0 << (int'(pos) + 1));
						if (m != '0) begin
							p = low_one(m);
							a.ok = 1'b1;
							a.found_key = KEY_W'(p * WORD_W + low_one(leaf_bits[p]));
						end
					end
				end
			end
			default: ;
		endcase
		if (!a.ok) a.found_key = '0;
		return a;
	endfunction

	// Present one item, hold it until taken, then maybe leave a gap
	task automatic offer_item(input logic [2:0] o, input logic [KEY_W-1:0] k,
			input logic pinned, input answer_t pinned_ans);
		answer_t a;
		in_valid <= 1'b1;
		op <= o;
		key <= k;
		do @(posedge clk); while (!in_ready);
		a = apply_set_op(o, k);
		answers_due.push_back(pinned ? pinned_ans : a);
		last_key = k;
		if (!calm && $urandom_range(0, 99) < 27) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 27);
		end
	endtask

	// Hold the input side until every pending answer is back
	task automatic await_drain();
		in_valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
	endtask

	function automatic logic [2:0] pick_op(input logic filling);
		int r;
		int ins_w;
		int era_w;
		r = $urandom_range(0, 99);
		ins_w = filling ? 34 : 12;
		era_w = filling ? 10 : 45;
		if (r < ins_w) return OP_INSERT;
		r -= ins_w;
		if (r < era_w) return OP_ERASE;
		r -= era_w;
		if (r < 10) return OP_CONTAINS;
		if (r < 14) return OP_MIN;
		if (r < 18) return OP_MAX;
		if (r < 33) return OP_PRED;
		if (r < 53) return OP_SUCC;
		return OP_RESERVED;
	endfunction

	// Keys cluster on a few leaves, the ends of the range and the last key,
	// with erases often aimed at a live member
	function automatic logic [KEY_W-1:0] pick_key(input logic aim_member);
		int r;
		answer_t probe;
		r = $urandom_range(0, 99);
		if (aim_member && r < 60) begin
			probe = apply_set_op(OP_SUCC, KEY_W'($urandom_range(0, 4095)));
			if (probe.ok) return probe.found_key;
			probe = top_member();
			if (probe.ok) return probe.found_key;
		end
		r = $urandom_range(0, 99);
		if (r < 30) return {hot[$urandom_range(0, 3)], IDX_W'($urandom_range(0, 63))};
		if (r < 45)
			return $urandom_range(0, 1) ? KEY_W'($urandom_range(0, 127))
				: KEY_W'(4095 - $urandom_range(0, 127));
		if (r < 65) return last_key + KEY_W'($urandom_range(0, 6)) - KEY_W'(3);
		return KEY_W'($urandom_range(0, 4095));
	endfunction

	// Take results and compare with the oldest pending answer
	always @(posedge clk) begin : sink
		answer_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					flag_mismatch($sformatf("result ok=%0d key=%0d with nothing pending",
						ok, found_key));
				end else begin
					want = answers_due.pop_front();
					if (ok !== want.ok)
						flag_mismatch($sformatf("ok=%0d, want %0d", ok, want.ok));
					if (found_key !== want.found_key)
						flag_mismatch($sformatf("found_key=%0d, want %0d",
							found_key, want.found_key));
				end
			end
			out_ready <= calm || ($urandom_range(0, 99) >= 27);
		end
	end

	initial begin
		logic [2:0] o;
		summary_bits = '0;
		foreach (leaf_bits[i]) leaf_bits[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (DIRECTED[i])
			offer_item(DIRECTED[i].op, DIRECTED[i].key, DIRECTED[i].pinned, DIRECTED[i].want);
		await_drain();

		// Random phases alternate between growing and shrinking the set
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			calm <= (ph == 4);
			hot[0] = '0;
			hot[1] = '1;
			hot[2] = IDX_W'($urandom_range(0, 63));
			hot[3] = IDX_W'($urandom_range(0, 63));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				o = pick_op(ph % 2 == 0);
				offer_item(o, pick_key(o == OP_ERASE), 1'b0, '0);
			end
			if (ph % 3 == 1) await_drain();
		end

		await_drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(10_000_000);
		$display("status: fail");
		$finish;
	end

endmodule

[hierarchical_bitmap_ordered_set_top.f]
hw/rtl/hbos_pkg.sv
hw/rtl/hbos_bit_find.sv
hw/rtl/hbos_leaf_ram.sv
hw/rtl/hierarchical_bitmap_ordered_set_top.sv
hw/rtl/hbos_checker.sv
dv/tb_top.sv
